// ===== hw/rtl/dhq_pkg.sv =====
// shared types and constants of the deadline min-heap queue
`timescale 1ns / 1ps
package dhq_pkg;

  // task ids are 5 bits wide, so the position map has this many entries
  localparam int TaskIds = 32;
  localparam int KeyW    = 64;
  localparam int TidW    = 5;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOTQ  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // one heap slot
  typedef struct packed {
    logic [TidW-1:0] tid;
    logic [KeyW-1:0] key;
  } dhq_entry_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_TAKE,
    OP_RD_LAST,
    OP_TAKE,
    OP_INS,
    OP_RD_PAR,
    OP_UP,
    OP_RD_L,
    OP_RD_R,
    OP_CMP_R,
    OP_DOWN,
    OP_PLACE,
    OP_RD_ROOT,
    OP_RESULT
  } dhq_op_e;

  // source of the result word
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_REM,
    RES_ROOT,
    RES_PEEK
  } dhq_res_e;

  // controller to datapath
  typedef struct packed {
    dhq_op_e    op;
    dhq_res_e   res_sel;
    logic [1:0] res_status;
  } dhq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       id_ok;
    logic       queued;
    logic       empty;
    logic       full;
    logic       hole_gone;
    logic       hole_root;
    logic       strict;
    logic       l_ok;
    logic       r_ok;
    logic       up_go;
    logic       down_go;
    logic       out_free;
  } dhq_flags_t;

endpackage

// ===== hw/rtl/deadline_min_heap_queue_unit.sv =====
// top level of the deadline min-heap queue
//
// Keeps up to NUM_TASKS tasks ordered by 64-bit unsigned deadline in a binary
// min-heap, with a map from task id to heap slot. The input stream carries
// one command word (add or requeue, remove by id, pop earliest, peek
// earliest); the output stream returns exactly one result word per command.
// Commands are handled one at a time. A pop, a remove or a requeue takes a
// task out and an add inserts one; the moved task climbs or descends the heap
// level by level, the heap memory giving one read or one write a cycle.
// The result sits in an output register; the next command is taken while it
// waits, and only its own result waits until the receiver takes the word.
// Reset empties the queue and marks every task not queued; heap slots need no
// clearing pass since only slots below the count are ever read.
`timescale 1ns / 1ps
module deadline_min_heap_queue_unit #(
  parameter int NUM_TASKS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // command[1:0], task_id[6:2], deadline[70:7], now[134:71], zero fill
  input  logic [135:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[1:0], out_task[6:2], out_deadline[70:7], time_left[134:71],
  // occupancy[140:135], zero fill
  output logic [143:0] m_axis_tdata_o
);
  import dhq_pkg::*;

  dhq_ctl_t   ctl;
  dhq_flags_t flags;
  logic [1:0]             status;
  logic [TidW-1:0]        out_task;
  logic [KeyW-1:0]        out_deadline;
  logic signed [KeyW-1:0] time_left;
  logic [5:0]             occupancy;

  dhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .flags_i   (flags),
    .ctl_o     (ctl)
  );

  dhq_datapath #(
    .NUM_TASKS(NUM_TASKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (s_axis_tdata_i[1:0]),
    .tid_i         (s_axis_tdata_i[6:2]),
    .deadline_i    (s_axis_tdata_i[70:7]),
    .now_i         (s_axis_tdata_i[134:71]),
    .ctl_i         (ctl),
    .flags_o       (flags),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .out_task_o    (out_task),
    .out_deadline_o(out_deadline),
    .time_left_o   (time_left),
    .occupancy_o   (occupancy)
  );

  // pack the result word
  assign m_axis_tdata_o = {3'd0, occupancy, time_left, out_deadline, out_task, status};
endmodule

// ===== hw/rtl/dhq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module dhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/dhq_datapath.sv =====
// heap memory, position map, sift registers and result word
`timescale 1ns / 1ps
module dhq_datapath #(
  parameter int NUM_TASKS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   cmd_i,
  input  logic [dhq_pkg::TidW-1:0]     tid_i,
  input  logic [dhq_pkg::KeyW-1:0]     deadline_i,
  input  logic [dhq_pkg::KeyW-1:0]     now_i,
  input  dhq_pkg::dhq_ctl_t            ctl_i,
  output dhq_pkg::dhq_flags_t          flags_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [dhq_pkg::TidW-1:0]     out_task_o,
  output logic [dhq_pkg::KeyW-1:0]     out_deadline_o,
  output logic signed [dhq_pkg::KeyW-1:0] time_left_o,
  output logic [5:0]                   occupancy_o
);
  import dhq_pkg::*;

  localparam int IW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int XW = IW + 2;

  // captured word and control registers
  logic [1:0]      cmd_q;
  logic [TidW-1:0] id_q;
  logic [KeyW-1:0] dl_q, now_q;
  logic [IW-1:0]   tk_q, hole_q, cand_idx_q;
  logic [CW-1:0]   cnt_q;
  logic            strict_q;
  dhq_entry_t      mov_q, rem_q, cand_q, rd;
  logic [IW-1:0]   pos_q [TaskIds];
  logic [TaskIds-1:0] queued_q;
  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [TidW-1:0] otask_q;
  logic [KeyW-1:0] okey_q, left_q;
  logic [5:0]      occ_q;

  logic [IW-1:0]   parent;
  logic [XW-1:0]   lchild, rchild;
  logic            re, we;
  logic [IW-1:0]   raddr;
  dhq_entry_t      wdata;
  logic [$bits(dhq_entry_t)-1:0] rdata;

  // child and parent indexes of the hole
  assign parent = (hole_q - IW'(1)) >> 1;
  assign lchild = {1'b0, hole_q, 1'b1};
  assign rchild = {1'b0, hole_q, 1'b0} + XW'(2);
  assign rd     = dhq_entry_t'(rdata);

  // status toward the controller
  always_comb begin
    flags_o.cmd       = cmd_q;
    flags_o.id_ok     = ({27'd0, id_q} < 32'(NUM_TASKS));
    flags_o.queued    = flags_o.id_ok && queued_q[id_q] && (CW'(pos_q[id_q]) < cnt_q);
    flags_o.empty     = (cnt_q == '0);
    flags_o.full      = (cnt_q >= CW'(NUM_TASKS));
    flags_o.hole_gone = (CW'(hole_q) == cnt_q);
    flags_o.hole_root = (hole_q == '0);
    flags_o.strict    = strict_q;
    flags_o.l_ok      = (lchild < XW'(cnt_q));
    flags_o.r_ok      = (rchild < XW'(cnt_q));
    flags_o.up_go     = strict_q ? (mov_q.key < rd.key) : !(rd.key < mov_q.key);
    flags_o.down_go   = (cand_q.key < mov_q.key);
    flags_o.out_free  = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    wdata = mov_q;
    case (ctl_i.op)
      OP_RD_TAKE: begin re = 1'b1; raddr = tk_q; end
      OP_RD_LAST: begin re = 1'b1; raddr = IW'(cnt_q - CW'(1)); end
      OP_RD_PAR:  begin re = 1'b1; raddr = parent; end
      OP_RD_L:    begin re = 1'b1; raddr = lchild[IW-1:0]; end
      OP_RD_R:    begin re = flags_o.r_ok; raddr = rchild[IW-1:0]; end
      OP_RD_ROOT: begin re = 1'b1; raddr = '0; end
      OP_UP:      begin we = 1'b1; wdata = rd; end
      OP_DOWN:    begin we = 1'b1; wdata = cand_q; end
      OP_PLACE:   begin we = 1'b1; wdata = mov_q; end
      default: ;
    endcase
  end

  dhq_ram #(
    .Width($bits(dhq_entry_t)),
    .Depth(NUM_TASKS)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(hole_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // count, queued bits, strict flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      queued_q    <= '0;
      strict_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctl_i.op)
        OP_TAKE: begin
          cnt_q              <= cnt_q - CW'(1);
          queued_q[rem_q.tid] <= 1'b0;
          strict_q           <= 1'b1;
        end
        OP_INS: begin
          cnt_q    <= cnt_q + CW'(1);
          strict_q <= 1'b0;
        end
        OP_UP:    strict_q <= 1'b0;
        OP_PLACE: queued_q[mov_q.tid] <= 1'b1;
        default: ;
      endcase
      if (ctl_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        cmd_q <= cmd_i;
        id_q  <= tid_i;
        dl_q  <= deadline_i;
        now_q <= now_i;
        tk_q  <= (cmd_i == CMD_POP) ? '0 : pos_q[tid_i];
      end
      OP_RD_LAST: rem_q <= rd;
      OP_TAKE: begin
        mov_q  <= rd;
        hole_q <= tk_q;
      end
      OP_INS: begin
        mov_q.tid <= id_q;
        mov_q.key <= dl_q;
        hole_q    <= IW'(cnt_q);
      end
      OP_UP: begin
        pos_q[rd.tid] <= hole_q;
        hole_q        <= parent;
      end
      OP_RD_R: begin
        cand_q     <= rd;
        cand_idx_q <= lchild[IW-1:0];
      end
      OP_CMP_R: begin
        if (rd.key < cand_q.key) begin
          cand_q     <= rd;
          cand_idx_q <= rchild[IW-1:0];
        end
      end
      OP_DOWN: begin
        pos_q[cand_q.tid] <= hole_q;
        hole_q            <= cand_idx_q;
      end
      OP_PLACE: pos_q[mov_q.tid] <= hole_q;
      OP_RESULT: begin
        status_q <= ctl_i.res_status;
        occ_q    <= 6'(cnt_q);
        case (ctl_i.res_sel)
          RES_REM: begin
            otask_q <= rem_q.tid;
            okey_q  <= rem_q.key;
            left_q  <= '0;
          end
          RES_ROOT: begin
            otask_q <= rd.tid;
            okey_q  <= rd.key;
            left_q  <= '0;
          end
          RES_PEEK: begin
            otask_q <= rd.tid;
            okey_q  <= rd.key;
            left_q  <= rd.key - now_q;
          end
          default: begin
            otask_q <= '0;
            okey_q  <= '0;
            left_q  <= '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_task_o     = otask_q;
  assign out_deadline_o = okey_q;
  assign time_left_o    = left_q;
  assign occupancy_o    = occ_q;
endmodule

// ===== hw/rtl/dhq_ctrl.sv =====
// command sequencer: take-out, insert, sift-up and sift-down steps
`timescale 1ns / 1ps
module dhq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dhq_pkg::dhq_flags_t  flags_i,
  output dhq_pkg::dhq_ctl_t    ctl_o
);
  import dhq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_TK_RD, S_TK_LAST, S_TK_CAP, S_TK_CHK,
    S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R, S_DN_CR, S_DN_CMP,
    S_PLACE, S_POST, S_INS, S_ROOT_RD, S_OUT
  } state_e;

  state_e     state_q;
  logic       ins_q;
  dhq_res_e   res_sel_q;
  logic [1:0] res_status_q;

  // state, insert phase and result selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ins_q        <= 1'b0;
      res_sel_q    <= RES_ZERO;
      res_status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ins_q   <= 1'b0;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_sel_q    <= RES_ZERO;
          res_status_q <= ST_OK;
          if ((flags_i.cmd == CMD_ADD || flags_i.cmd == CMD_REMOVE) && !flags_i.id_ok) begin
            res_status_q <= ST_NOTQ;
            state_q      <= S_OUT;
          end else if (flags_i.cmd == CMD_REMOVE) begin
            if (flags_i.queued) begin
              state_q <= S_TK_RD;
            end else begin
              res_status_q <= ST_NOTQ;
              state_q      <= S_OUT;
            end
          end else if (flags_i.cmd == CMD_ADD) begin
            state_q <= flags_i.queued ? S_TK_RD : S_INS;
          end else if (flags_i.empty) begin
            res_status_q <= ST_EMPTY;
            state_q      <= S_OUT;
          end else if (flags_i.cmd == CMD_POP) begin
            state_q <= S_TK_RD;
          end else begin
            res_sel_q <= RES_PEEK;
            state_q   <= S_ROOT_RD;
          end
        end
        S_TK_RD:   state_q <= S_TK_LAST;
        S_TK_LAST: state_q <= S_TK_CAP;
        S_TK_CAP:  state_q <= S_TK_CHK;
        S_TK_CHK: begin
          if (flags_i.hole_gone) begin
            state_q <= S_POST;
          end else if (flags_i.hole_root) begin
            state_q <= S_DN_L;
          end else begin
            state_q <= S_UP_RD;
          end
        end
        S_UP_RD: state_q <= flags_i.hole_root ? S_PLACE : S_UP_CMP;
        S_UP_CMP: begin
          if (flags_i.up_go) begin
            state_q <= S_UP_RD;
          end else if (flags_i.strict) begin
            state_q <= S_DN_L;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_DN_L:   state_q <= flags_i.l_ok ? S_DN_R : S_PLACE;
        S_DN_R:   state_q <= flags_i.r_ok ? S_DN_CR : S_DN_CMP;
        S_DN_CR:  state_q <= S_DN_CMP;
        S_DN_CMP: state_q <= flags_i.down_go ? S_DN_L : S_PLACE;
        S_PLACE:  state_q <= S_POST;
        S_POST: begin
          if (ins_q) begin
            res_sel_q <= RES_ROOT;
            state_q   <= S_ROOT_RD;
          end else if (flags_i.cmd == CMD_ADD) begin
            state_q <= S_INS;
          end else begin
            res_sel_q <= RES_REM;
            state_q   <= S_OUT;
          end
        end
        S_INS: begin
          if (flags_i.full) begin
            res_sel_q    <= RES_ROOT;
            res_status_q <= ST_FULL;
            state_q      <= S_ROOT_RD;
          end else begin
            ins_q   <= 1'b1;
            state_q <= S_UP_RD;
          end
        end
        S_ROOT_RD: state_q <= S_OUT;
        S_OUT: begin
          if (flags_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath operation of the current step
  always_comb begin
    ctl_o.op         = OP_NONE;
    ctl_o.res_sel    = res_sel_q;
    ctl_o.res_status = res_status_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) ctl_o.op = OP_LOAD;
      S_TK_RD:   ctl_o.op = OP_RD_TAKE;
      S_TK_LAST: ctl_o.op = OP_RD_LAST;
      S_TK_CAP:  ctl_o.op = OP_TAKE;
      S_UP_RD:   if (!flags_i.hole_root) ctl_o.op = OP_RD_PAR;
      S_UP_CMP:  if (flags_i.up_go) ctl_o.op = OP_UP;
      S_DN_L:    if (flags_i.l_ok) ctl_o.op = OP_RD_L;
      S_DN_R:    ctl_o.op = OP_RD_R;
      S_DN_CR:   ctl_o.op = OP_CMP_R;
      S_DN_CMP:  if (flags_i.down_go) ctl_o.op = OP_DOWN;
      S_PLACE:   ctl_o.op = OP_PLACE;
      S_INS:     if (!flags_i.full) ctl_o.op = OP_INS;
      S_ROOT_RD: ctl_o.op = OP_RD_ROOT;
      S_OUT:     if (flags_i.out_free) ctl_o.op = OP_RESULT;
      default:   ctl_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

// ===== hw/rtl/dhq_checker.sv =====
// port-level checks of the deadline min-heap queue, bound to the top level
`timescale 1ns / 1ps
module dhq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [143:0] m_axis_tdata_o
);
  import dhq_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // an empty answer reports no task and an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == ST_EMPTY |->
      m_axis_tdata_o[140:135] == 6'd0 && m_axis_tdata_o[70:2] == '0)
    else $error("empty status with non-empty fields");

  // only a successful command carries time left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK |-> m_axis_tdata_o[134:71] == '0)
    else $error("time left on a failed command");

  // a full answer means a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == ST_FULL |-> m_axis_tdata_o[140:135] != 6'd0)
    else $error("full status with zero occupancy");
endmodule

bind deadline_min_heap_queue_unit dhq_checker u_dhq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
